@@ sv/tle_pkg.sv @@
// ----------------------------------------------------------------------------
// tle_pkg
// shared types and constants of the terminal line editor
// ----------------------------------------------------------------------------
package tle_pkg;

    localparam int LEN_W = 5;

    localparam logic [2:0] MODE_NORMAL = 3'd0;
    localparam logic [2:0] MODE_ESC    = 3'd1;
    localparam logic [2:0] MODE_SEQ1   = 3'd2;
    localparam logic [2:0] MODE_SEQ2   = 3'd3;
    localparam logic [2:0] MODE_SEQ3   = 3'd4;
    localparam logic [2:0] MODE_SEQ4   = 3'd5;
    localparam logic [2:0] MODE_DEL    = 3'd6;

    localparam logic [1:0] KIND_ECHO = 2'd0;
    localparam logic [1:0] KIND_LINE = 2'd1;
    localparam logic [1:0] KIND_MARK = 2'd2;

    localparam logic [1:0] SRC_LIT   = 2'd0;
    localparam logic [1:0] SRC_STORE = 2'd1;
    localparam logic [1:0] SRC_PFX   = 2'd2;

    localparam logic [3:0] OP_NONE    = 4'd0;
    localparam logic [3:0] OP_LEFT    = 4'd1;
    localparam logic [3:0] OP_RIGHT   = 4'd2;
    localparam logic [3:0] OP_HOME    = 4'd3;
    localparam logic [3:0] OP_END     = 4'd4;
    localparam logic [3:0] OP_DELBACK = 4'd5;
    localparam logic [3:0] OP_DELFWD  = 4'd6;
    localparam logic [3:0] OP_INS     = 4'd7;
    localparam logic [3:0] OP_CLEAR   = 4'd8;

    localparam logic [3:0] ACT_NONE  = 4'd0;
    localparam logic [3:0] ACT_LEFT  = 4'd1;
    localparam logic [3:0] ACT_RIGHT = 4'd2;
    localparam logic [3:0] ACT_HOME  = 4'd3;
    localparam logic [3:0] ACT_END   = 4'd4;
    localparam logic [3:0] ACT_BKSP  = 4'd5;
    localparam logic [3:0] ACT_FDEL  = 4'd6;
    localparam logic [3:0] ACT_INS   = 4'd7;
    localparam logic [3:0] ACT_ENTER = 4'd8;
    localparam logic [3:0] ACT_CTRLC = 4'd9;

    localparam logic [7:0] CH_ETX   = 8'h03;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_2     = 8'h32;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_4     = 8'h34;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_8     = 8'h38;
    localparam logic [7:0] CH_UC    = 8'h43;
    localparam logic [7:0] CH_UD    = 8'h44;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UH    = 8'h48;
    localparam logic [7:0] CH_UO    = 8'h4F;

    // fixed echo strings: ^C CR LF at 0..3, CR LF at 2..3, backspace at 4
    localparam logic [4:0] FIX_CTRLC_FIRST = 5'd0;
    localparam logic [4:0] FIX_CRLF_FIRST  = 5'd2;
    localparam logic [4:0] FIX_BS_FIRST    = 5'd4;
    localparam logic [4:0] FIX_CRLF_LAST   = 5'd3;
    localparam logic [4:0] FIX_BS_LAST     = 5'd4;

    function automatic logic [7:0] fix_char(input logic [4:0] idx);
        logic [7:0] ch;
        case (idx)
            5'd0:    ch = CH_CARET;
            5'd1:    ch = CH_UC;
            5'd2:    ch = CH_CR;
            5'd3:    ch = CH_LF;
            default: ch = CH_BS;
        endcase
        return ch;
    endfunction

    typedef struct packed {
        logic             load;
        logic             upd;
        logic [2:0]       mode;
        logic [3:0]       op;
        logic             gen;
        logic [1:0]       src;
        logic [7:0]       lit;
        logic [1:0]       kind;
        logic             flush;
        logic [LEN_W-1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic [7:0]       c;
        logic [2:0]       mode;
        logic [7:0]       prev;
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] cur;
        logic [3:0]       plen;
        logic             gen_ok;
        logic             pend_valid;
    } sts_t;

endpackage

@@ sv/tle_dp.sv @@
// ----------------------------------------------------------------------------
// tle_dp
// line store, cursor, mode registers and output staging of the line editor
// ----------------------------------------------------------------------------
module tle_dp #(
    parameter int LINE_DEPTH = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [7:0]    s_in_byte,
    input  tle_pkg::cmd_t cmd,
    input  logic [63:0]   prefix_text,
    input  logic [3:0]    prefix_length,
    input  logic          m_ready,
    output tle_pkg::sts_t sts,
    output logic          m_valid,
    output logic [7:0]    m_out_byte,
    output logic [1:0]    m_out_kind,
    output logic          m_last_of_run
);

    localparam int LW = tle_pkg::LEN_W;
    localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    logic [7:0]    line_reg [LINE_DEPTH];
    logic [7:0]    line_next [LINE_DEPTH];
    logic [7:0]    byte_reg;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] cur_reg, cur_next;
    logic [2:0]    mode_reg;
    logic [7:0]    prev_reg;
    logic [7:0]    pend_byte_reg;
    logic [1:0]    pend_kind_reg;
    logic          pend_valid_reg, pend_valid_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg;
    logic [1:0]    out_kind_reg;
    logic          out_last_reg;
    logic          gen_ok;
    logic          push;
    logic [7:0]    gen_byte;

    assign gen_ok = !out_valid_reg || m_ready;
    assign push   = (cmd.gen || cmd.flush) && pend_valid_reg && gen_ok;

    always_comb begin
        case (cmd.src)
            tle_pkg::SRC_STORE: gen_byte = line_reg[cmd.idx[AW-1:0]];
            tle_pkg::SRC_PFX:   gen_byte = prefix_text[{cmd.idx[2:0], 3'b000} +: 8];
            default:            gen_byte = cmd.lit;
        endcase
    end

    // shift network: each entry looks only at its neighbors and the input byte
    always_comb begin
        for (int i = 0; i < LINE_DEPTH; i++) begin
            line_next[i] = line_reg[i];
            case (cmd.op)
                tle_pkg::OP_DELBACK: begin
                    if (LW'(i) + LW'(1) >= cur_reg && i < LINE_DEPTH - 1)
                        line_next[i] = line_reg[(i + 1) % LINE_DEPTH];
                end
                tle_pkg::OP_DELFWD: begin
                    if (LW'(i) >= cur_reg && i < LINE_DEPTH - 1)
                        line_next[i] = line_reg[(i + 1) % LINE_DEPTH];
                end
                tle_pkg::OP_INS: begin
                    if (LW'(i) == cur_reg)
                        line_next[i] = byte_reg;
                    else if (LW'(i) > cur_reg)
                        line_next[i] = line_reg[(i + LINE_DEPTH - 1) % LINE_DEPTH];
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        len_next = len_reg;
        cur_next = cur_reg;
        unique case (cmd.op)
            tle_pkg::OP_LEFT:    cur_next = cur_reg - LW'(1);
            tle_pkg::OP_RIGHT:   cur_next = cur_reg + LW'(1);
            tle_pkg::OP_HOME:    cur_next = '0;
            tle_pkg::OP_END:     cur_next = len_reg;
            tle_pkg::OP_DELBACK: begin
                len_next = len_reg - LW'(1);
                cur_next = cur_reg - LW'(1);
            end
            tle_pkg::OP_DELFWD:  len_next = len_reg - LW'(1);
            tle_pkg::OP_INS: begin
                len_next = len_reg + LW'(1);
                cur_next = cur_reg + LW'(1);
            end
            tle_pkg::OP_CLEAR: begin
                len_next = '0;
                cur_next = '0;
            end
            default: ;
        endcase
    end

    always_comb begin
        pend_valid_next = pend_valid_reg;
        if (cmd.gen && gen_ok)
            pend_valid_next = 1'b1;
        else if (push)
            pend_valid_next = 1'b0;
        out_valid_next = out_valid_reg;
        if (push)
            out_valid_next = 1'b1;
        else if (m_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < LINE_DEPTH; i++)
            line_reg[i] <= line_next[i];
        if (cmd.load)
            byte_reg <= s_in_byte;
        if (cmd.gen && gen_ok) begin
            pend_byte_reg <= gen_byte;
            pend_kind_reg <= cmd.kind;
        end
        if (push) begin
            out_byte_reg <= pend_byte_reg;
            out_kind_reg <= pend_kind_reg;
            out_last_reg <= cmd.flush;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg        <= '0;
            cur_reg        <= '0;
            mode_reg       <= tle_pkg::MODE_NORMAL;
            prev_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            len_reg        <= len_next;
            cur_reg        <= cur_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cmd.upd) begin
                mode_reg <= cmd.mode;
                prev_reg <= byte_reg;
            end
        end
    end

    assign sts.c          = byte_reg;
    assign sts.mode       = mode_reg;
    assign sts.prev       = prev_reg;
    assign sts.len        = len_reg;
    assign sts.cur        = cur_reg;
    assign sts.plen       = prefix_length;
    assign sts.gen_ok     = gen_ok;
    assign sts.pend_valid = pend_valid_reg;

    assign m_valid       = out_valid_reg;
    assign m_out_byte    = out_byte_reg;
    assign m_out_kind    = out_kind_reg;
    assign m_last_of_run = out_last_reg;

endmodule

@@ sv/tle_ctrl.sv @@
// ----------------------------------------------------------------------------
// tle_ctrl
// escape parser, action decode and echo sequencer of the line editor
// ----------------------------------------------------------------------------
module tle_ctrl #(
    parameter int LINE_DEPTH = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  tle_pkg::sts_t sts,
    output tle_pkg::cmd_t cmd
);

    localparam int LW = tle_pkg::LEN_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_MOVE  = 4'd2;
    localparam logic [3:0] S_FIX   = 4'd3;
    localparam logic [3:0] S_STR   = 4'd4;
    localparam logic [3:0] S_SP    = 4'd5;
    localparam logic [3:0] S_BS    = 4'd6;
    localparam logic [3:0] S_MARK  = 4'd7;
    localparam logic [3:0] S_PFX   = 4'd8;
    localparam logic [3:0] S_FLUSH = 4'd9;

    logic [3:0]    state_reg, state_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic [1:0]    sub_reg, sub_next;
    logic [3:0]    act_reg, act_next;
    logic [3:0]    act;
    logic [2:0]    nmode;
    logic          act_ok;
    logic          is_lf;
    logic [LW-1:0] bs_cnt;
    logic [LW-1:0] pfx_cnt;
    logic [LW-1:0] fix_last;

    assign is_lf   = sts.c == tle_pkg::CH_LF;
    assign bs_cnt  = (act_reg == tle_pkg::ACT_INS) ? sts.len - sts.cur
                                                   : sts.len - sts.cur + LW'(1);
    assign pfx_cnt = (sts.plen > 4'd8) ? LW'(8) : LW'(sts.plen);
    assign fix_last = (act_reg == tle_pkg::ACT_BKSP) ? tle_pkg::FIX_BS_LAST
                                                     : tle_pkg::FIX_CRLF_LAST;

    // escape parser and byte decode
    always_comb begin
        act   = tle_pkg::ACT_NONE;
        nmode = tle_pkg::MODE_NORMAL;
        unique case (sts.mode)
            tle_pkg::MODE_ESC: begin
                if (sts.c == tle_pkg::CH_LBRK || sts.c == tle_pkg::CH_UO)
                    nmode = tle_pkg::MODE_SEQ1;
            end
            tle_pkg::MODE_SEQ1: begin
                case (sts.c) inside
                    tle_pkg::CH_UC: act = tle_pkg::ACT_RIGHT;
                    tle_pkg::CH_UD: act = tle_pkg::ACT_LEFT;
                    tle_pkg::CH_UF: act = tle_pkg::ACT_END;
                    tle_pkg::CH_UH: act = tle_pkg::ACT_HOME;
                    tle_pkg::CH_3:  nmode = tle_pkg::MODE_DEL;
                    tle_pkg::CH_UO, tle_pkg::CH_1, tle_pkg::CH_2, tle_pkg::CH_4,
                    tle_pkg::CH_7, tle_pkg::CH_8: nmode = tle_pkg::MODE_SEQ2;
                    default: ;
                endcase
            end
            tle_pkg::MODE_SEQ2: begin
                if (sts.c == tle_pkg::CH_TILDE)
                    act = tle_pkg::ACT_HOME;
                else if (sts.c == tle_pkg::CH_0 && sts.prev == tle_pkg::CH_2)
                    nmode = tle_pkg::MODE_SEQ3;
            end
            tle_pkg::MODE_SEQ3: begin
                if (sts.c == tle_pkg::CH_0 || sts.c == tle_pkg::CH_1)
                    nmode = tle_pkg::MODE_SEQ4;
            end
            tle_pkg::MODE_SEQ4: ;
            tle_pkg::MODE_DEL: begin
                if (sts.c == tle_pkg::CH_TILDE)
                    act = tle_pkg::ACT_FDEL;
            end
            default: begin
                case (sts.c) inside
                    tle_pkg::CH_ESC:                 nmode = tle_pkg::MODE_ESC;
                    tle_pkg::CH_DEL, tle_pkg::CH_BS: act = tle_pkg::ACT_BKSP;
                    tle_pkg::CH_LF, tle_pkg::CH_CR:  act = tle_pkg::ACT_ENTER;
                    tle_pkg::CH_ETX:                 act = tle_pkg::ACT_CTRLC;
                    default:                         act = tle_pkg::ACT_INS;
                endcase
            end
        endcase
    end

    always_comb begin
        unique case (act)
            tle_pkg::ACT_LEFT, tle_pkg::ACT_HOME, tle_pkg::ACT_BKSP:
                act_ok = sts.cur != '0;
            tle_pkg::ACT_RIGHT, tle_pkg::ACT_END, tle_pkg::ACT_FDEL:
                act_ok = sts.cur < sts.len;
            tle_pkg::ACT_INS:
                act_ok = sts.c >= tle_pkg::CH_SP && sts.c <= tle_pkg::CH_TILDE
                         && sts.len < LW'(LINE_DEPTH - 1);
            tle_pkg::ACT_ENTER, tle_pkg::ACT_CTRLC:
                act_ok = 1'b1;
            default:
                act_ok = 1'b0;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        sub_next   = sub_reg;
        act_next   = act_reg;
        cmd        = '0;
        cmd.lit    = tle_pkg::CH_BS;
        cmd.kind   = tle_pkg::KIND_ECHO;
        cmd.src    = tle_pkg::SRC_LIT;
        cmd.mode   = nmode;
        cmd.idx    = idx_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid)
                    state_next = S_DEC;
            end
            S_DEC: begin
                cmd.upd    = 1'b1;
                act_next   = act_ok ? act : tle_pkg::ACT_NONE;
                sub_next   = '0;
                state_next = S_FLUSH;
                if (act_ok) begin
                    unique case (act)
                        tle_pkg::ACT_LEFT: begin
                            cmd.op = tle_pkg::OP_LEFT;
                            idx_next = LW'(1);
                            state_next = S_MOVE;
                        end
                        tle_pkg::ACT_RIGHT: begin
                            cmd.op = tle_pkg::OP_RIGHT;
                            idx_next = LW'(1);
                            state_next = S_MOVE;
                        end
                        tle_pkg::ACT_HOME: begin
                            cmd.op = tle_pkg::OP_HOME;
                            idx_next = sts.cur;
                            state_next = S_MOVE;
                        end
                        tle_pkg::ACT_END: begin
                            cmd.op = tle_pkg::OP_END;
                            idx_next = sts.len - sts.cur;
                            state_next = S_MOVE;
                        end
                        tle_pkg::ACT_BKSP: begin
                            cmd.op = tle_pkg::OP_DELBACK;
                            idx_next = tle_pkg::FIX_BS_FIRST;
                            state_next = S_FIX;
                        end
                        tle_pkg::ACT_FDEL: begin
                            cmd.op = tle_pkg::OP_DELFWD;
                            idx_next = sts.cur;
                            state_next = S_STR;
                        end
                        tle_pkg::ACT_INS: begin
                            cmd.op = tle_pkg::OP_INS;
                            idx_next = sts.cur;
                            state_next = S_STR;
                        end
                        tle_pkg::ACT_ENTER: begin
                            if (sts.len != '0) begin
                                idx_next = tle_pkg::FIX_CRLF_FIRST;
                                state_next = S_FIX;
                            end else if (is_lf) begin
                                idx_next = '0;
                                state_next = S_PFX;
                            end
                        end
                        tle_pkg::ACT_CTRLC: begin
                            cmd.op = tle_pkg::OP_CLEAR;
                            idx_next = tle_pkg::FIX_CTRLC_FIRST;
                            state_next = S_FIX;
                        end
                        default: ;
                    endcase
                end
            end
            S_MOVE: begin
                cmd.gen = 1'b1;
                unique case (sub_reg)
                    2'd0:    cmd.lit = tle_pkg::CH_ESC;
                    2'd1:    cmd.lit = tle_pkg::CH_LBRK;
                    default: cmd.lit = (act_reg == tle_pkg::ACT_LEFT
                                        || act_reg == tle_pkg::ACT_HOME)
                                       ? tle_pkg::CH_UD : tle_pkg::CH_UC;
                endcase
                if (sts.gen_ok) begin
                    if (sub_reg == 2'd2) begin
                        sub_next = '0;
                        idx_next = idx_reg - LW'(1);
                        if (idx_reg == LW'(1))
                            state_next = S_FLUSH;
                    end else begin
                        sub_next = sub_reg + 2'd1;
                    end
                end
            end
            S_FIX: begin
                cmd.gen = 1'b1;
                cmd.lit = tle_pkg::fix_char(idx_reg);
                if (sts.gen_ok) begin
                    idx_next = idx_reg + LW'(1);
                    if (idx_reg == fix_last) begin
                        if (act_reg == tle_pkg::ACT_CTRLC) begin
                            idx_next = '0;
                            state_next = S_PFX;
                        end else if (act_reg == tle_pkg::ACT_ENTER) begin
                            idx_next = '0;
                            state_next = S_STR;
                        end else begin
                            idx_next = sts.cur;
                            state_next = S_STR;
                        end
                    end
                end
            end
            S_STR: begin
                if (idx_reg >= sts.len) begin
                    idx_next = '0;
                    if (act_reg == tle_pkg::ACT_ENTER)
                        state_next = S_MARK;
                    else if (act_reg == tle_pkg::ACT_INS)
                        state_next = S_BS;
                    else
                        state_next = S_SP;
                end else begin
                    cmd.gen  = 1'b1;
                    cmd.src  = tle_pkg::SRC_STORE;
                    cmd.kind = (act_reg == tle_pkg::ACT_ENTER) ? tle_pkg::KIND_LINE
                                                               : tle_pkg::KIND_ECHO;
                    if (sts.gen_ok)
                        idx_next = idx_reg + LW'(1);
                end
            end
            S_SP: begin
                cmd.gen = 1'b1;
                cmd.lit = tle_pkg::CH_SP;
                if (sts.gen_ok) begin
                    idx_next = '0;
                    state_next = S_BS;
                end
            end
            S_BS: begin
                if (idx_reg >= bs_cnt) begin
                    state_next = S_FLUSH;
                end else begin
                    cmd.gen = 1'b1;
                    cmd.lit = tle_pkg::CH_BS;
                    if (sts.gen_ok)
                        idx_next = idx_reg + LW'(1);
                end
            end
            S_MARK: begin
                cmd.gen  = 1'b1;
                cmd.lit  = 8'h00;
                cmd.kind = tle_pkg::KIND_MARK;
                if (sts.gen_ok) begin
                    cmd.op = tle_pkg::OP_CLEAR;
                    idx_next = '0;
                    state_next = is_lf ? S_PFX : S_FLUSH;
                end
            end
            S_PFX: begin
                if (idx_reg >= pfx_cnt) begin
                    state_next = S_FLUSH;
                end else begin
                    cmd.gen = 1'b1;
                    cmd.src = tle_pkg::SRC_PFX;
                    if (sts.gen_ok)
                        idx_next = idx_reg + LW'(1);
                end
            end
            S_FLUSH: begin
                cmd.flush = 1'b1;
                if (!sts.pend_valid || sts.gen_ok)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            sub_reg   <= '0;
            act_reg   <= tle_pkg::ACT_NONE;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            sub_reg   <= sub_next;
            act_reg   <= act_next;
        end
    end

endmodule

@@ sv/terminal_line_editor.sv @@
// ----------------------------------------------------------------------------
// terminal_line_editor
// editable command line with cursor, escape parsing and echo redraw
// ----------------------------------------------------------------------------
//  port group  direction  contents
//  s_*         in         one terminal byte per transaction
//  m_*         out        echo, line character or end marker per transaction
//  p*          in/out     prompt text at 0x0, prompt length at 0x8
//
//  each input byte is taken only in the idle state, then decoded, echoed
//  by the sequencer and flushed before s_ready rises for the next byte
//  the echo sequencer emits one result per cycle into a one-entry stage
//  ahead of the output register; a stalled m_ready holds the sequencer
//  synchronous active-low reset clears the line, cursor, mode and prompt
// ----------------------------------------------------------------------------
module terminal_line_editor #(
    parameter int LINE_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic [1:0]  m_out_kind,
    output logic        m_last_of_run,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    tle_pkg::cmd_t cmd;
    tle_pkg::sts_t sts;
    logic [63:0]   prefix_text_reg;
    logic [3:0]    prefix_length_reg;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = paddr[3] ? {60'b0, prefix_length_reg} : prefix_text_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_text_reg   <= '0;
            prefix_length_reg <= '0;
        end else if (cfg_wr) begin
            if (paddr[3])
                prefix_length_reg <= pwdata[3:0];
            else
                prefix_text_reg <= pwdata;
        end
    end

    tle_ctrl #(
        .LINE_DEPTH(LINE_DEPTH)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    tle_dp #(
        .LINE_DEPTH(LINE_DEPTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_in_byte     (s_in_byte),
        .cmd           (cmd),
        .prefix_text   (prefix_text_reg),
        .prefix_length (prefix_length_reg),
        .m_ready       (m_ready),
        .sts           (sts),
        .m_valid       (m_valid),
        .m_out_byte    (m_out_byte),
        .m_out_kind    (m_out_kind),
        .m_last_of_run (m_last_of_run)
    );

    a_cursor_in_line: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.cur <= sts.len)
        else $error("cursor beyond line end");

    a_line_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.len < tle_pkg::LEN_W'(LINE_DEPTH))
        else $error("line length overflow");

    a_idle_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !sts.pend_valid)
        else $error("input taken with a result still staged");

endmodule
